/* rtl/c3g_pkg.sv */
`default_nettype none
package c3g_pkg;

    localparam int MaxWidthDefault = 1024;
    localparam int MaxHeight       = 4096;

    localparam logic [10:0] WidthReset   = 11'd512;
    localparam logic [12:0] HeightReset  = 13'd512;
    localparam logic [23:0] KTopReset    = 24'hFFFFFF;
    localparam logic [23:0] KMidReset    = 24'hFF01FF;
    localparam logic [23:0] KBotReset    = 24'hFFFFFF;
    localparam logic [11:0] DivisorReset = 12'hFF9;

    localparam int SumWidth = 20;
    localparam int QuoWidth = 20;

    typedef enum logic [2:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_KTOP    = 3'd2,
        REG_KMID    = 3'd3,
        REG_KBOT    = 3'd4,
        REG_DIVISOR = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take_pixel;
        logic start_sum;
        logic start_div;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic interior;
        logic div_done;
        logic use_div;
    } status_t;

endpackage
`default_nettype wire

/* rtl/c3g_stream_if.sv */
`default_nettype none
interface c3g_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/c3g_ctrl.sv */
`default_nettype none
module c3g_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire c3g_pkg::status_t sts,
    output c3g_pkg::cmd_t        cmd
);
    import c3g_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a new result at this edge
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_READ;
            ST_READ: state_next = sts.interior ? ST_SUM : ST_IDLE;
            ST_SUM:
            begin
                if (sts.use_div)
                    state_next = ST_DIV;
                else
                    state_next = out_free ? ST_IDLE : ST_OUT;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = out_free ? ST_IDLE : ST_OUT;
            end
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.take_pixel = in_valid;
            end
            ST_READ:
            begin
                cmd.start_sum = sts.interior;
            end
            ST_SUM:
            begin
                cmd.start_div = sts.use_div;
                cmd.load_out  = !sts.use_div && out_free;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.load_out = sts.div_done && out_free;
            end
            ST_OUT:
            begin
                cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end
endmodule
`default_nettype wire

/* rtl/c3g_datapath.sv */
`default_nettype none
module c3g_datapath #(
    parameter int MAX_WIDTH = c3g_pkg::MaxWidthDefault
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [23:0]       cfg_data,
    input  wire logic [7:0]        pixel_in,
    input  wire c3g_pkg::cmd_t     cmd,
    output c3g_pkg::status_t       sts,
    output logic [7:0]             pixel_out,
    output logic [11:0]            out_row,
    output logic [9:0]             out_column,
    output logic                   frame_last
);
    import c3g_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [23:0] krow_reg [3];
    logic [11:0] div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WidthReset;
            height_reg  <= HeightReset;
            krow_reg[0] <= KTopReset;
            krow_reg[1] <= KMidReset;
            krow_reg[2] <= KBotReset;
            div_reg     <= DivisorReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:   width_reg   <= cfg_data[10:0];
                REG_HEIGHT:  height_reg  <= cfg_data[12:0];
                REG_KTOP:    krow_reg[0] <= cfg_data;
                REG_KMID:    krow_reg[1] <= cfg_data;
                REG_KBOT:    krow_reg[2] <= cfg_data;
                REG_DIVISOR: div_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [CW-1:0] w_used;
    logic [12:0]   h_used;
    always_comb
    begin
        if (width_reg < 11'd3)
            w_used = CW'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            w_used = CW'(MAX_WIDTH);
        else
            w_used = CW'(width_reg);
        if (height_reg < 13'd3)
            h_used = 13'd3;
        else if (height_reg > 13'(MaxHeight))
            h_used = 13'(MaxHeight);
        else
            h_used = height_reg;
    end

    // position of the next pixel; wrap first if geometry shrank
    logic [CW-1:0] col_reg;
    logic [12:0]   row_reg;
    logic [CW-1:0] c_eff;
    logic [12:0]   r_eff, r_tmp;
    always_comb
    begin
        c_eff = col_reg;
        r_tmp = row_reg;
        if (col_reg >= w_used)
        begin
            c_eff = '0;
            r_tmp = row_reg + 13'd1;
        end
        r_eff = (r_tmp >= h_used) ? 13'd0 : r_tmp;
    end

    // line stores
    logic [7:0] line1_mem [MAX_WIDTH];
    logic [7:0] line2_mem [MAX_WIDTH];
    logic [7:0] l1_rd_reg, l2_rd_reg;
    logic [7:0] px_reg;
    logic [CW-1:0] c_reg;
    logic [12:0]   r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel)
        begin
            l1_rd_reg <= line1_mem[c_eff[AW-1:0]];
            l2_rd_reg <= line2_mem[c_eff[AW-1:0]];
            px_reg    <= pixel_in;
            c_reg     <= c_eff;
            r_reg     <= r_eff;
        end
    end

    // fetch cycle done: update line stores, window, position
    logic pend_reg;
    logic [7:0] win_reg [6];
    logic [CW-1:0] c_inc;
    logic [12:0]   r_inc;
    assign c_inc = c_reg + CW'(1);
    assign r_inc = r_reg + 13'd1;

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            line2_mem[c_reg[AW-1:0]] <= l1_rd_reg;
            line1_mem[c_reg[AW-1:0]] <= px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            pend_reg <= cmd.take_pixel;
            if (pend_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= l2_rd_reg;
                win_reg[4] <= l1_rd_reg;
                win_reg[5] <= px_reg;
                if (c_inc >= w_used)
                begin
                    col_reg <= '0;
                    row_reg <= (r_inc >= h_used) ? 13'd0 : r_inc;
                end
                else
                begin
                    col_reg <= c_inc;
                    row_reg <= r_reg;
                end
            end
        end
    end

    assign sts.interior = (r_reg >= 13'd2) && (c_reg >= CW'(2));
    assign sts.use_div  = (div_reg != 12'd0);

    // weighted sum, computed in READ state from pre-shift window
    logic [7:0] pix9 [9];
    logic signed [SumWidth-1:0] sum_c;
    always_comb
    begin
        logic signed [SumWidth-1:0] pix_s;
        logic signed [SumWidth-1:0] coef_s;
        pix9[0] = win_reg[0]; pix9[1] = win_reg[3]; pix9[2] = l2_rd_reg;
        pix9[3] = win_reg[1]; pix9[4] = win_reg[4]; pix9[5] = l1_rd_reg;
        pix9[6] = win_reg[2]; pix9[7] = win_reg[5]; pix9[8] = px_reg;
        sum_c = '0;
        for (int rr = 0; rr < 3; rr++)
        begin
            for (int cc = 0; cc < 3; cc++)
            begin
                pix_s  = SumWidth'($signed({1'b0, pix9[3 * rr + cc]}));
                coef_s = SumWidth'($signed(krow_reg[rr][8 * cc +: 8]));
                sum_c  = sum_c + SumWidth'(pix_s * coef_s);
            end
        end
    end

    logic signed [SumWidth-1:0] sum_reg;
    logic [11:0] r_out_reg;
    logic [9:0]  c_out_reg;
    logic        last_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.start_sum)
        begin
            sum_reg   <= sum_c;
            r_out_reg <= 12'(r_reg - 13'd1);
            c_out_reg <= 10'(c_reg - CW'(1));
            last_reg  <= (r_reg == h_used - 13'd1) && (c_reg == w_used - CW'(1));
        end
    end

    // restoring divider on magnitudes, one bit per cycle
    logic [QuoWidth-1:0] rem_reg, quo_reg, mag_s;
    logic [11:0] mag_d;
    logic [4:0]  cnt_reg;
    logic        neg_reg;
    logic [QuoWidth:0] trial;
    assign mag_s = sum_reg[SumWidth-1] ? QuoWidth'(-sum_reg) : QuoWidth'(sum_reg);
    assign mag_d = div_reg[11] ? 12'(-div_reg) : div_reg;
    assign trial = {rem_reg, quo_reg[QuoWidth-1]} - (QuoWidth + 1)'(mag_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start_div)
        begin
            cnt_reg <= 5'(QuoWidth);
        end
        else if (cmd.div_step && cnt_reg != 5'd0)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            rem_reg <= '0;
            quo_reg <= mag_s;
            neg_reg <= sum_reg[SumWidth-1] ^ div_reg[11];
        end
        else if (cmd.div_step && cnt_reg != 5'd0)
        begin
            if (!trial[QuoWidth])
            begin
                rem_reg <= trial[QuoWidth-1:0];
                quo_reg <= {quo_reg[QuoWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[QuoWidth-2:0], quo_reg[QuoWidth-1]};
                quo_reg <= {quo_reg[QuoWidth-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = (cnt_reg == 5'd0);

    logic [7:0] res_c;
    assign res_c = sts.use_div ? (neg_reg ? 8'(-quo_reg) : quo_reg[7:0]) : sum_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pixel_out  <= res_c;
            out_row    <= r_out_reg;
            out_column <= c_out_reg;
            frame_last <= last_reg;
        end
    end
endmodule
`default_nettype wire

/* rtl/conv3x3_grayscale_filter.sv */
`default_nettype none
// channel   | dir | payload
// ----------+-----+----------------------------------------------
// pix_in    | in  | pixel_in[7:0]
// pix_out   | out | pixel_out, out_row, out_column, frame_last
// cfg       | in  | index[2:0], data[23:0]
//
// Border pixel: the transaction passes the accept and line store read
// states. Interior pixel: also the sum state, plus the bit-serial divider
// when divisor is nonzero; the divider sets the rate.
// The output register holds one result; the next pixel is accepted while
// it waits, and a new result stalls only if the previous one is not taken.
// rst_n is asynchronous; config registers come back to their documented values.
// Line stores need no clearing pass: entries are written before read.
module conv3x3_grayscale_filter #(
    parameter int MAX_WIDTH = c3g_pkg::MaxWidthDefault
) (
    input  wire logic clk,
    input  wire logic rst_n,
    c3g_stream_if.sink   pix_in,
    c3g_stream_if.source pix_out,
    c3g_stream_if.sink   cfg
);
    import c3g_pkg::*;

    cmd_t    cmd;
    status_t sts;
    logic    out_valid;

    logic [7:0]  pixel_out;
    logic [11:0] out_row;
    logic [9:0]  out_column;
    logic        frame_last;

    // config writes taken at any time (only legal while idle)
    assign cfg.ready = 1'b1;

    c3g_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (out_valid),
        .out_ready (pix_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    c3g_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.data[26:24]),
        .cfg_data   (cfg.data[23:0]),
        .pixel_in   (pix_in.data),
        .cmd        (cmd),
        .sts        (sts),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_column (out_column),
        .frame_last (frame_last)
    );

    assign pix_out.valid = out_valid;
    assign pix_out.data  = {frame_last, out_column, out_row, pixel_out};
endmodule
`default_nettype wire

/* tb/conv3x3_grayscale_filter_tb.sv */
`default_nettype none
module conv3x3_grayscale_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3g_pkg::*;

    // pixel mixes for a frame
    localparam int MixRandom = 0;
    localparam int MixWhite  = 1;
    localparam int MixBlack  = 2;
    localparam int MixCheck  = 3;

    // output payload is {frame_last, out_column, out_row, pixel_out}
    localparam int OutW = 8 + 12 + 10 + 1;
    // cycles to let a trailing border pixel drain before a register write
    localparam int DrainCycles = 60;
    // cycles with no transaction on any channel before giving up
    localparam int WatchdogLimit = 4000;

    typedef struct packed {
        logic        last;
        logic [9:0]  column;
        logic [11:0] row;
        logic [7:0]  pixel;
    } filtered_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    c3g_stream_if #(.W(8))    pin  ();
    c3g_stream_if #(.W(OutW)) pout ();
    c3g_stream_if #(.W(27))   cfg  ();

    conv3x3_grayscale_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pin.sink),
        .pix_out (pout.source),
        .cfg     (cfg.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int mismatches = 0;

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Tracks the block's geometry, line stores and window, and queues the
    // filtered pixel each accepted input pixel should produce.
    class pixel_scoreboard;
        int unsigned width_reg, height_reg;
        logic [23:0] krow[3];
        logic [11:0] div_reg;
        logic [7:0]  above1[1024];
        logic [7:0]  above2[1024];
        logic [7:0]  win_cols[6];
        int unsigned row_pos, col_pos;
        filtered_t   pending[$];
        int unsigned results_seen;

        function new();
            width_reg  = WidthReset;
            height_reg = HeightReset;
            krow[0]    = KTopReset;
            krow[1]    = KMidReset;
            krow[2]    = KBotReset;
            div_reg    = DivisorReset;
            foreach (above1[i]) above1[i] = '0;
            foreach (above2[i]) above2[i] = '0;
            foreach (win_cols[i]) win_cols[i] = '0;
            row_pos = 0;
            col_pos = 0;
            results_seen = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [23:0] v);
            case (idx)
                REG_WIDTH:   width_reg  = v[10:0];
                REG_HEIGHT:  height_reg = v[12:0];
                REG_KTOP:    krow[0]    = v;
                REG_KMID:    krow[1]    = v;
                REG_KBOT:    krow[2]    = v;
                REG_DIVISOR: div_reg    = v[11:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [7:0] px);
            int unsigned w, h, c, r;
            logic [7:0] win[3][3];
            int sum, d;
            filtered_t e;
            w = (width_reg < 3) ? 3 : (width_reg > 1024) ? 1024 : width_reg;
            h = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
            // geometry may have shrunk under the current position
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            c = col_pos;
            r = row_pos;
            for (int i = 0; i < 3; i++)
            begin
                win[i][0] = win_cols[i];
                win[i][1] = win_cols[3 + i];
            end
            win[0][2] = above2[c];
            win[1][2] = above1[c];
            win[2][2] = px;
            if (r >= 2 && c >= 2)
            begin
                sum = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        sum += int'(win[i][j]) * int'($signed(krow[i][8*j +: 8]));
                d = int'($signed(div_reg));
                if (d != 0) sum = sum / d;
                e.pixel  = sum[7:0];
                e.row    = 12'(r - 1);
                e.column = 10'(c - 1);
                e.last   = (r == h - 1) && (c == w - 1);
                pending.push_back(e);
            end
            above2[c] = win[1][2];
            above1[c] = px;
            for (int i = 0; i < 3; i++)
            begin
                win_cols[i]     = win[i][1];
                win_cols[3 + i] = win[i][2];
            end
            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        task check_result(filtered_t got);
            filtered_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                report("unexpected result, pixel", got.pixel, -1);
                return;
            end
            want = pending.pop_front();
            if (got.pixel != want.pixel)   report("pixel_out", got.pixel, want.pixel);
            if (got.row != want.row)       report("out_row", got.row, want.row);
            if (got.column != want.column) report("out_column", got.column, want.column);
            if (got.last != want.last)     report("frame_last", got.last, want.last);
        endtask
    endclass

    pixel_scoreboard filt_sb = new();

    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;
    int unsigned pixels_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned idle_cycles = 0;

    initial
    begin
        pin.valid  = 1'b0;
        pin.data   = '0;
        cfg.valid  = 1'b0;
        cfg.data   = '0;
        pout.ready = 1'b0;
    end

    // Receiver stalls: alternates stretches of full acceptance with
    // stretches of random back-pressure.
    int unsigned stall_phase = 0;
    always @(posedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 80) pout.ready <= 1'b1;
        else if (stall_phase < 200) pout.ready <= ($urandom_range(0, 3) != 0);
        else pout.ready <= ($urandom_range(0, 1) != 0);
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && pout.valid && pout.ready)
            filt_sb.check_result(filtered_t'(pout.data));

    // watchdog on transaction-free cycles
    always @(posedge clk)
    begin
        if ((pin.valid && pin.ready) || (pout.valid && pout.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("conv3x3_grayscale_filter verification failed");
            $finish;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [23:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= {idx, v};
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        filt_sb.write_reg(idx, v);
        cfg.valid <= 1'b0;
    endtask

    // wait until all expected results are in, then let the block drain
    task automatic wait_idle();
        if (pin.valid)
        begin
            pin.valid <= 1'b0;
            @(posedge clk);
        end
        while (filt_sb.pending.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] px);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                pin.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        pin.valid <= 1'b1;
        pin.data  <= px;
        @(posedge clk);
        while (!pin.ready) @(posedge clk);
        filt_sb.note_pixel(px);
        pixels_sent++;
        burst_left--;
    endtask

    function automatic logic [7:0] mix_pixel(int mix, int unsigned k);
        case (mix)
            MixWhite: return 8'hFF;
            MixBlack: return 8'h00;
            MixCheck: return k[0] ? 8'hFF : 8'h00;
            default:  return 8'($urandom);
        endcase
    endfunction

    task automatic send_pixels(input int unsigned n, input int mix);
        for (int unsigned k = 0; k < n; k++) send_pixel(mix_pixel(mix, k));
    endtask

    task automatic setup(input logic [23:0] w, input logic [23:0] h, input logic [23:0] kt,
                         input logic [23:0] km, input logic [23:0] kb, input logic [23:0] dv);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_KTOP, kt);
        write_reg(REG_KMID, km);
        write_reg(REG_KBOT, kb);
        write_reg(REG_DIVISOR, dv);
    endtask

    // one whole frame at the clamped geometry, then idle
    task automatic run_frame(input int unsigned w, input int unsigned h, input int mix);
        send_pixels(w * h, mix);
        frames_sent++;
        wait_idle();
    endtask

    function automatic logic [23:0] rand_divisor();
        case ($urandom_range(0, 7))
            0: return 24'h000;
            1: return 24'h001;
            2: return 24'hFFF;
            3: return 24'(12'(-1152));
            4: return 24'd1152;
            default: return 24'($urandom_range(0, 4095));
        endcase
    endfunction

    initial
    begin
        int unsigned w, h;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset kernel and divisor on a small frame.
        write_reg(REG_WIDTH, 24'd5);
        write_reg(REG_HEIGHT, 24'd4);
        run_frame(5, 4, MixRandom);
        // Largest positive sum, no division: wraps to the low byte.
        setup(24'd3, 24'd3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'd0);
        run_frame(3, 3, MixWhite);
        // Most negative coefficients with divisor -1.
        setup(24'd4, 24'd3, 24'h808080, 24'h808080, 24'h808080, 24'hFFF);
        run_frame(4, 3, MixCheck);
        // Zero picture, under-range geometry clamps to 3x3.
        setup(24'd0, 24'd1, 24'h01FF80, 24'h7F0001, 24'h80FF7F, 24'd1152);
        run_frame(3, 3, MixBlack);
        setup(24'd2, 24'd2, 24'h01FF80, 24'h7F0001, 24'h80FF7F, 24'h800);
        run_frame(3, 3, MixWhite);

        // Geometry changed mid-frame: full frame at width 8 writes the line
        // stores, then a partial frame, then the width and height shrink.
        setup(24'd8, 24'd5, 24'h010201, 24'h020402, 24'h010201, 24'd16);
        run_frame(8, 5, MixRandom);
        send_pixels(8 * 2 + 6, MixRandom);
        wait_idle();
        write_reg(REG_WIDTH, 24'd5);
        write_reg(REG_HEIGHT, 24'd3);
        // finish current row and wrap through more frames
        send_pixels(5 * 3 * 2 + 4, MixRandom);
        wait_idle();
        // realign to a frame start
        send_pixels((15 - ((filt_sb.row_pos * 5 + filt_sb.col_pos) % 15)) % 15, MixRandom);
        wait_idle();

        // Random frames, small geometry.
        while (pixels_sent < 1200)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            setup(24'(w), 24'(h), 24'($urandom), 24'($urandom), 24'($urandom),
                  rand_divisor());
            for (int f = $urandom_range(1, 2); f > 0; f--)
                run_frame(w, h, ($urandom_range(0, 9) == 0) ? MixCheck : MixRandom);
        end

        wait_idle();
        $display("covered %0d pixels in %0d frames, %0d filtered results checked",
                 pixels_sent, frames_sent, filt_sb.results_seen);
        $display("geometry from 3x3 up to 12x8, clamped and mid-frame resized, all registers");
        if (mismatches == 0 && filt_sb.pending.size() == 0)
            $display("conv3x3_grayscale_filter verification clean");
        else
            $display("conv3x3_grayscale_filter verification failed");
        $finish;
    end
endmodule
`default_nettype wire
